### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition is never seen at a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### rtl/fic_pkg.sv
`default_nettype none

package fic_pkg;

    localparam int TIMESTAMP_BITS       = 16;
    localparam int INTERVAL_BITS        = 16;
    localparam int PERIOD_BITS          = 17;
    localparam int COUNTER_BITS_DEFAULT = 16;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 17'h0FFFF;

    // Event codes
    localparam logic [2:0] MODE_CAPTURE = 3'd0;
    localparam logic [2:0] MODE_INDEX   = 3'd1;
    localparam logic [2:0] MODE_START   = 3'd2;
    localparam logic [2:0] MODE_SERVICE = 3'd3;
    localparam logic [2:0] MODE_STOP    = 3'd4;

    // Phase codes as reported on the result word
    localparam logic [2:0] PHASE_CODE_IDLE     = 3'd0;
    localparam logic [2:0] PHASE_CODE_WAIT     = 3'd1;
    localparam logic [2:0] PHASE_CODE_SAMPLING = 3'd2;
    localparam logic [2:0] PHASE_CODE_STOPPING = 3'd3;
    localparam logic [2:0] PHASE_CODE_ERROR    = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_WAIT     = 5'b00010,
        PH_SAMPLING = 5'b00100,
        PH_STOPPING = 5'b01000,
        PH_ERROR    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [2:0]                mode;
        logic [TIMESTAMP_BITS-1:0] timestamp;
        logic                      sink_full;
    } event_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] interval;
        logic                     interval_valid;
        logic                     sample_dropped;
        logic                     overflow_reported;
        logic [2:0]               phase_now;
    } result_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:     code = PHASE_CODE_IDLE;
            PH_WAIT:     code = PHASE_CODE_WAIT;
            PH_SAMPLING: code = PHASE_CODE_SAMPLING;
            PH_STOPPING: code = PHASE_CODE_STOPPING;
            PH_ERROR:    code = PHASE_CODE_ERROR;
            default:     code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/fic_if.sv
`default_nettype none

interface fic_event_if;
    import fic_pkg::*;

    logic   valid;
    logic   ready;
    event_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fic_result_if;
    import fic_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/flux_interval_capture_control_core.sv
// Flux interval capture control.
//
// evt carries one event word per handshake: mode (capture edge, index pulse,
// start, service tick, stop), the capture counter timestamp and the sink-full
// flag. Every accepted event returns exactly one word on res with the
// interval (wrapped modulo the counter period), taken/dropped flags, the
// overflow report and the phase after the event.
// cfg_we/cfg_wdata write the counter period; write it only while idle.
//
// Throughput: one event per cycle while res is not stalled. Each event passes
// through the input register, then the result register. The phase and
// last-capture registers update in the same cycle the event leaves the
// input register, so back-to-back events see each other's effects.
// Reset clears phase to idle, last capture to zero, period to 65535 and
// empties both registers. When res stalls the result word holds, the input
// register fills, and evt.ready drops until res is taken.

`default_nettype none

`include "assert_macros.svh"

module flux_interval_capture_control_core #(
    parameter int CounterBits = fic_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [fic_pkg::PERIOD_BITS-1:0]    cfg_wdata,
    fic_event_if.sink                               evt,
    fic_result_if.source                            res
);
    import fic_pkg::*;

    // Only the low interval bits of the period reach the 16-bit result.
    logic [INTERVAL_BITS-1:0] period_reg;

    logic    in_valid_reg;
    event_t  in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    advance;
    logic    step;
    result_t step_res;

    assign advance   = !out_valid_reg || res.ready;
    assign step      = in_valid_reg && advance;
    assign evt.ready = !in_valid_reg || advance;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET[INTERVAL_BITS-1:0];
        else if (cfg_we)
            period_reg <= cfg_wdata[INTERVAL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
                in_valid_reg <= evt.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
            in_data_reg <= evt.data;
        if (step)
            out_data_reg <= step_res;
    end

    fic_sequencer #(
        .CounterBits (CounterBits)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .period (period_reg),
        .step   (step),
        .ev     (in_data_reg),
        .res    (step_res)
    );

    `ASSERT_PROP(a_ready_only_on_stall, clk, rst_n, !evt.ready |-> (res.valid && !res.ready), "input stalled without output stall")
    `ASSERT_PROP(a_overflow_idle, clk, rst_n, (res.valid && res.data.overflow_reported) |-> (res.data.phase_now == PHASE_CODE_IDLE), "overflow word not idle")
    `ASSERT_PROP(a_drop_error, clk, rst_n, (res.valid && res.data.sample_dropped) |-> (res.data.phase_now == PHASE_CODE_ERROR), "dropped word not in error")
    `ASSERT_PROP(a_step_fills_out, clk, rst_n, step |=> out_valid_reg, "processed event lost")

endmodule

`default_nettype wire

### rtl/fic_sequencer.sv
`default_nettype none

`include "assert_macros.svh"

module fic_sequencer #(
    parameter int CounterBits = fic_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [fic_pkg::INTERVAL_BITS-1:0]    period,
    input  wire logic                                 step,
    input  wire fic_pkg::event_t                      ev,
    output fic_pkg::result_t                          res
);
    import fic_pkg::*;

    // Only the low counter bits of a timestamp are kept.
    localparam int TsBits = (CounterBits < TIMESTAMP_BITS) ? CounterBits : TIMESTAMP_BITS;

    phase_t              phase_reg, phase_next;
    logic [TsBits-1:0]   last_capture_reg, last_capture_next;

    logic [TsBits-1:0]         ts_cut;
    logic [INTERVAL_BITS-1:0]  ts_word;
    logic [INTERVAL_BITS-1:0]  prev_word;
    logic [INTERVAL_BITS-1:0]  diff;
    logic [INTERVAL_BITS-1:0]  interval;
    logic                      capturing;

    assign ts_cut    = ev.timestamp[TsBits-1:0];
    assign ts_word   = INTERVAL_BITS'(ts_cut);
    assign prev_word = INTERVAL_BITS'(last_capture_reg);
    assign diff      = ts_word - prev_word;
    // Counter wrapped since the last capture: add the period back in.
    assign interval  = (ts_cut < last_capture_reg) ? (diff + period) : diff;
    assign capturing = (phase_reg == PH_SAMPLING) || (phase_reg == PH_STOPPING)
                       || (phase_reg == PH_ERROR);

    always_comb
    begin
        phase_next        = phase_reg;
        last_capture_next = last_capture_reg;
        res               = '0;
        case (ev.mode)
            MODE_CAPTURE:
            begin
                if (capturing)
                begin
                    res.interval      = interval;
                    last_capture_next = ts_cut;
                    if (ev.sink_full)
                    begin
                        res.sample_dropped = 1'b1;
                        phase_next         = PH_ERROR;
                    end
                    else
                    begin
                        res.interval_valid = 1'b1;
                    end
                end
            end
            MODE_INDEX:
            begin
                if (phase_reg == PH_SAMPLING)
                    phase_next = PH_STOPPING;
                else if (phase_reg == PH_WAIT)
                    phase_next = PH_SAMPLING;
            end
            MODE_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    last_capture_next = ts_cut;
                    phase_next        = PH_WAIT;
                end
            end
            MODE_SERVICE:
            begin
                if (phase_reg == PH_ERROR)
                begin
                    res.overflow_reported = 1'b1;
                    phase_next            = PH_IDLE;
                end
                else if (phase_reg == PH_STOPPING)
                begin
                    phase_next = PH_IDLE;
                end
            end
            MODE_STOP:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        res.phase_now = phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            last_capture_reg <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            last_capture_reg <= last_capture_next;
        end
    end

    `ASSERT_PROP(a_phase_onehot, clk, rst_n, $onehot(phase_reg), "phase register not one-hot")
    `ASSERT_NEVER(a_valid_and_drop, clk, rst_n, res.interval_valid && res.sample_dropped, "interval both taken and dropped")
    `ASSERT_PROP(a_drop_to_error, clk, rst_n, (step && res.sample_dropped) |=> (phase_reg == PH_ERROR), "dropped capture did not enter error")
    `ASSERT_PROP(a_overflow_from_error, clk, rst_n, res.overflow_reported |-> (phase_reg == PH_ERROR), "overflow reported outside error")

endmodule

`default_nettype wire
